// ===== rtl/slip_response_frame_receiver_assert.svh =====
// Assertion macros shared by the receiver's modules.
// Each macro takes a label, the clock, the active-low reset and two expressions.
`ifndef SLIP_RESPONSE_FRAME_RECEIVER_ASSERT_SVH
`define SLIP_RESPONSE_FRAME_RECEIVER_ASSERT_SVH

`ifndef SYNTHESIS

`define SRFR_ASSERT_IMPLY(lbl, clk_s, rstn_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!(rstn_s)) (ante) |-> (cons)) \
    else $error("assertion failed");

`define SRFR_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!(rstn_s)) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define SRFR_ASSERT_IMPLY(lbl, clk_s, rstn_s, ante, cons)

`define SRFR_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons)

`endif

`endif

// ===== rtl/srfr_pkg.sv =====
// ----------------------------------------------------------------------------
// srfr_pkg
// Types and constants of the SLIP response frame receiver.
// ----------------------------------------------------------------------------
`default_nettype none

package srfr_pkg;

  // Input actions
  localparam logic [1:0] ACT_ARM  = 2'd0;
  localparam logic [1:0] ACT_BYTE = 2'd1;
  localparam logic [1:0] ACT_TICK = 2'd2;

  // Receiver phase codes
  localparam logic [1:0] PH_HUNT = 2'd0;
  localparam logic [1:0] PH_SKIP = 2'd1;
  localparam logic [1:0] PH_BODY = 2'd2;

  // SLIP bytes
  localparam logic [7:0] SLIP_END     = 8'hC0;
  localparam logic [7:0] SLIP_ESC     = 8'hDB;
  localparam logic [7:0] SLIP_ESC_END = 8'hDC;
  localparam logic [7:0] SLIP_ESC_ESC = 8'hDD;
  localparam logic [7:0] DIR_RESPONSE = 8'h01;

  // Result codes
  localparam logic [2:0] RES_OK        = 3'd0;
  localparam logic [2:0] RES_TIMEOUT   = 3'd1;
  localparam logic [2:0] RES_OVERFLOW  = 3'd2;
  localparam logic [2:0] RES_SHORT     = 3'd3;
  localparam logic [2:0] RES_NOT_RESP  = 3'd4;
  localparam logic [2:0] RES_OPCODE    = 3'd5;
  localparam logic [2:0] RES_SIZE_BIG  = 3'd6;
  localparam logic [2:0] RES_SIZE_LOW  = 3'd7;

  // Register indexes
  localparam logic REG_OPCODE  = 1'b0;
  localparam logic REG_TIMEOUT = 1'b1;

  localparam logic [7:0]  OPCODE_RESET  = 8'd8;
  localparam logic [15:0] TIMEOUT_RESET = 16'd100;

  typedef struct packed {
    logic [7:0]  want_opcode;
    logic [15:0] timeout_ticks;
  } cfg_t;

  typedef struct packed {
    logic [2:0]  result_code;
    logic [7:0]  status;
    logic [10:0] frame_length;
  } result_t;

endpackage

`default_nettype wire

// ===== rtl/srfr_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// srfr_cfg_regs
// APB-style register file holding the expected opcode and the tick timeout.
// ----------------------------------------------------------------------------
`default_nettype none

module srfr_cfg_regs (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           psel,
  input  wire logic           penable,
  input  wire logic           pwrite,
  input  wire logic [2:0]     paddr,
  input  wire logic [31:0]    pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  output srfr_pkg::cfg_t      cfg
);

  logic [7:0]  opcode_r;
  logic [15:0] timeout_r;
  logic        wr_en;

  // Word address only: the low address bits are not decoded.
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      opcode_r  <= srfr_pkg::OPCODE_RESET;
      timeout_r <= srfr_pkg::TIMEOUT_RESET;
    end else if (wr_en) begin
      if (paddr[2] == srfr_pkg::REG_OPCODE) begin
        opcode_r <= pwdata[7:0];
      end else begin
        timeout_r <= pwdata[15:0];
      end
    end
  end

  always_comb begin
    if (paddr[2] == srfr_pkg::REG_TIMEOUT) begin
      prdata = {16'd0, timeout_r};
    end else begin
      prdata = {24'd0, opcode_r};
    end
  end

  assign cfg.want_opcode   = opcode_r;
  assign cfg.timeout_ticks = timeout_r;

endmodule

`default_nettype wire

// ===== rtl/srfr_core.sv =====
// ----------------------------------------------------------------------------
// srfr_core
// Per-item state update: SLIP unescaping, header capture and frame checks.
// ----------------------------------------------------------------------------
`default_nettype none

`include "slip_response_frame_receiver_assert.svh"

module srfr_core #(
  parameter int MAX_FRAME    = 1048,
  parameter int HEADER_BYTES = 8
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           go,
  input  wire logic [1:0]     action,
  input  wire logic [7:0]     rx_byte,
  input  wire srfr_pkg::cfg_t cfg,
  output logic                res_valid,
  output srfr_pkg::result_t   res
);

  localparam int CNT_W = $clog2(MAX_FRAME + 1);
  localparam int SUM_W = 18;

  logic             armed_r, armed_nxt;
  logic [1:0]       phase_r, phase_nxt;
  logic             esc_r, esc_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [7:0]       dir_r, dir_nxt;
  logic [7:0]       opc_r, opc_nxt;
  logic [15:0]      size_r, size_nxt;
  logic [7:0]       stat_r, stat_nxt;
  logic [15:0]      elapsed_r, elapsed_nxt;

  logic             take;
  logic [7:0]       tb;
  logic [CNT_W-1:0] cnt_inc;
  logic [15:0]      el_inc;
  logic [SUM_W-1:0] n_ext;
  logic [SUM_W-1:0] hdr_size;
  logic [SUM_W-1:0] hdr_min;
  logic             is_end;
  logic [2:0]       close_code;

  assign is_end   = (rx_byte == srfr_pkg::SLIP_END);
  assign cnt_inc  = cnt_r + CNT_W'(1);
  assign el_inc   = (elapsed_r == 16'hFFFF) ? elapsed_r : elapsed_r + 16'd1;
  assign n_ext    = SUM_W'(cnt_r);
  assign hdr_size = SUM_W'(HEADER_BYTES) + SUM_W'(size_r);
  assign hdr_min  = SUM_W'(HEADER_BYTES + 4);

  // Checks at the closing delimiter, in order of precedence.
  always_comb begin
    if (n_ext < hdr_min) begin
      close_code = srfr_pkg::RES_SHORT;
    end else if (dir_r != srfr_pkg::DIR_RESPONSE) begin
      close_code = srfr_pkg::RES_NOT_RESP;
    end else if (opc_r != cfg.want_opcode) begin
      close_code = srfr_pkg::RES_OPCODE;
    end else if (hdr_size > n_ext) begin
      close_code = srfr_pkg::RES_SIZE_BIG;
    end else if (size_r < 16'd4) begin
      close_code = srfr_pkg::RES_SIZE_LOW;
    end else begin
      close_code = srfr_pkg::RES_OK;
    end
  end

  always_comb begin
    armed_nxt   = armed_r;
    phase_nxt   = phase_r;
    esc_nxt     = esc_r;
    cnt_nxt     = cnt_r;
    dir_nxt     = dir_r;
    opc_nxt     = opc_r;
    size_nxt    = size_r;
    stat_nxt    = stat_r;
    elapsed_nxt = elapsed_r;
    take        = 1'b0;
    tb          = rx_byte;
    res_valid   = 1'b0;
    res.result_code  = srfr_pkg::RES_OK;
    res.status       = 8'd0;
    res.frame_length = 11'd0;

    if (go) begin
      if (action == srfr_pkg::ACT_ARM) begin
        armed_nxt   = 1'b1;
        phase_nxt   = srfr_pkg::PH_HUNT;
        esc_nxt     = 1'b0;
        cnt_nxt     = '0;
        dir_nxt     = 8'd0;
        opc_nxt     = 8'd0;
        size_nxt    = 16'd0;
        stat_nxt    = 8'd0;
        elapsed_nxt = 16'd0;
      end else if (armed_r && action == srfr_pkg::ACT_TICK) begin
        elapsed_nxt = el_inc;
        if (el_inc >= cfg.timeout_ticks) begin
          res_valid       = 1'b1;
          res.result_code = srfr_pkg::RES_TIMEOUT;
        end
      end else if (armed_r && action == srfr_pkg::ACT_BYTE) begin
        case (phase_r)
          srfr_pkg::PH_HUNT: begin
            if (is_end) begin
              phase_nxt = srfr_pkg::PH_SKIP;
            end
          end
          srfr_pkg::PH_SKIP: begin
            // Repeated delimiters are skipped; the escape flag is clear here.
            if (!is_end) begin
              phase_nxt = srfr_pkg::PH_BODY;
              if (rx_byte == srfr_pkg::SLIP_ESC) begin
                esc_nxt = 1'b1;
              end else begin
                take = 1'b1;
              end
            end
          end
          srfr_pkg::PH_BODY: begin
            if (is_end) begin
              res_valid        = 1'b1;
              res.result_code  = close_code;
              res.status       = (close_code == srfr_pkg::RES_OK) ? stat_r : 8'd0;
              res.frame_length = 11'(cnt_r);
            end else if (esc_r) begin
              esc_nxt = 1'b0;
              take    = 1'b1;
              if (rx_byte == srfr_pkg::SLIP_ESC_END) begin
                tb = srfr_pkg::SLIP_END;
              end else if (rx_byte == srfr_pkg::SLIP_ESC_ESC) begin
                tb = srfr_pkg::SLIP_ESC;
              end
            end else if (rx_byte == srfr_pkg::SLIP_ESC) begin
              esc_nxt = 1'b1;
            end else begin
              take = 1'b1;
            end
          end
          default: begin
            phase_nxt = phase_r;
          end
        endcase
      end

      if (take) begin
        if (cnt_r == CNT_W'(0)) begin
          dir_nxt = tb;
        end else if (cnt_r == CNT_W'(1)) begin
          opc_nxt = tb;
        end else if (cnt_r == CNT_W'(2)) begin
          size_nxt = {size_r[15:8], tb};
        end else if (cnt_r == CNT_W'(3)) begin
          size_nxt = {tb, size_r[7:0]};
        end
        // Status sits at HEADER_BYTES + size - 4; compared with the four added
        // to the count side so that nothing wraps.
        if (cnt_r >= CNT_W'(4) && size_r >= 16'd4 &&
            (n_ext + SUM_W'(4)) == hdr_size) begin
          stat_nxt = tb;
        end
        cnt_nxt = cnt_inc;
        if (cnt_inc >= CNT_W'(MAX_FRAME)) begin
          res_valid       = 1'b1;
          res.result_code = srfr_pkg::RES_OVERFLOW;
        end
      end

      if (res_valid) begin
        armed_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      armed_r   <= 1'b0;
      phase_r   <= srfr_pkg::PH_HUNT;
      esc_r     <= 1'b0;
      cnt_r     <= '0;
      dir_r     <= 8'd0;
      opc_r     <= 8'd0;
      size_r    <= 16'd0;
      stat_r    <= 8'd0;
      elapsed_r <= 16'd0;
    end else begin
      armed_r   <= armed_nxt;
      phase_r   <= phase_nxt;
      esc_r     <= esc_nxt;
      cnt_r     <= cnt_nxt;
      dir_r     <= dir_nxt;
      opc_r     <= opc_nxt;
      size_r    <= size_nxt;
      stat_r    <= stat_nxt;
      elapsed_r <= elapsed_nxt;
    end
  end

  `SRFR_ASSERT_NEXT(a_arm_sets_armed, clk, rst_n, go && action == srfr_pkg::ACT_ARM, armed_r)
  `SRFR_ASSERT_NEXT(a_result_disarms, clk, rst_n, res_valid, !armed_r)
  `SRFR_ASSERT_IMPLY(a_fail_no_status, clk, rst_n,
                     res_valid && res.result_code != srfr_pkg::RES_OK, res.status == 8'd0)

endmodule

`default_nettype wire

// ===== rtl/srfr_out_buf.sv =====
// ----------------------------------------------------------------------------
// srfr_out_buf
// Two-entry result buffer that decouples the core from the output stall.
// ----------------------------------------------------------------------------
`default_nettype none

`include "slip_response_frame_receiver_assert.svh"

module srfr_out_buf (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire srfr_pkg::result_t push_data,
  output logic                   full,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output srfr_pkg::result_t      head
);

  logic [1:0]        count_r, count_nxt;
  srfr_pkg::result_t head_r, head_nxt;
  srfr_pkg::result_t second_r, second_nxt;
  logic              pop;

  assign pop       = (count_r != 2'd0) && !out_stall;
  assign full      = (count_r == 2'd2);
  assign out_valid = (count_r != 2'd0);
  assign head      = head_r;

  always_comb begin
    count_nxt  = count_r;
    head_nxt   = head_r;
    second_nxt = second_r;
    case (count_r)
      2'd0: begin
        if (push) begin
          head_nxt  = push_data;
          count_nxt = 2'd1;
        end
      end
      2'd1: begin
        if (push && pop) begin
          head_nxt = push_data;
        end else if (push) begin
          second_nxt = push_data;
          count_nxt  = 2'd2;
        end else if (pop) begin
          count_nxt = 2'd0;
        end
      end
      2'd2: begin
        if (pop) begin
          head_nxt  = second_r;
          count_nxt = 2'd1;
        end
      end
      default: begin
        count_nxt = 2'd0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= 2'd0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    head_r   <= head_nxt;
    second_r <= second_nxt;
  end

  `SRFR_ASSERT_IMPLY(a_count_range, clk, rst_n, 1'b1, count_r != 2'd3)
  `SRFR_ASSERT_IMPLY(a_no_push_when_full, clk, rst_n, push, count_r != 2'd2)

endmodule

`default_nettype wire

// ===== rtl/slip_response_frame_receiver.sv =====
// An item enters the input register; the core then updates its state and, on a
// verdict, pushes it into the two-entry result buffer, which drives out_valid.
// The input takes one item per cycle unless it stalls; it stalls only while the
// input register is full and the buffer is full.
// Reset clears the receiver to not armed and loads the register defaults.
// ----------------------------------------------------------------------------
// slip_response_frame_receiver
// Waits for one SLIP-framed response on a byte stream and reports its verdict.
// ----------------------------------------------------------------------------
`default_nettype none

module slip_response_frame_receiver #(
  parameter int MAX_FRAME    = 1048,
  parameter int HEADER_BYTES = 8
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_action,
  input  wire logic [7:0]  in_rx_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [2:0]       out_result_code,
  output logic [7:0]       out_resp_status,
  output logic [10:0]      out_frame_length,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  srfr_pkg::cfg_t    cfg;
  srfr_pkg::result_t core_res;
  srfr_pkg::result_t head;
  logic              core_res_valid;
  logic              buf_full;
  logic              s1_valid_r;
  logic [1:0]        s1_action_r;
  logic [7:0]        s1_byte_r;
  logic              s1_go;
  logic              in_take;

  // The registered item is processed whenever the buffer has room.
  assign s1_go    = s1_valid_r && !buf_full;
  assign in_stall = s1_valid_r && buf_full;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_take || s1_go) begin
      s1_valid_r <= in_take;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_action_r <= in_action;
      s1_byte_r   <= in_rx_byte;
    end
  end

  srfr_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  srfr_core #(
    .MAX_FRAME    (MAX_FRAME),
    .HEADER_BYTES (HEADER_BYTES)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .go        (s1_go),
    .action    (s1_action_r),
    .rx_byte   (s1_byte_r),
    .cfg       (cfg),
    .res_valid (core_res_valid),
    .res       (core_res)
  );

  srfr_out_buf u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (core_res_valid),
    .push_data (core_res),
    .full      (buf_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .head      (head)
  );

  assign out_result_code  = head.result_code;
  assign out_resp_status  = head.status;
  assign out_frame_length = head.frame_length;

endmodule

`default_nettype wire

// ===== test/slip_response_frame_receiver_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// slip_response_frame_receiver_tb
// Drives armed and unarmed byte streams, ticks and SLIP frames into the
// receiver, predicts every verdict and checks each one as it is transferred.
// ----------------------------------------------------------------------------

module slip_response_frame_receiver_tb;

  localparam int HDR_BYTES   = 8;
  localparam int FRAME_CAP   = 1048;
  localparam int HOLD_CYCLES = 300;
  localparam int QUIET_LIMIT = 4000;

  // The fourth action code does nothing in the block.
  localparam logic [1:0] ACT_NONE = 2'd3;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] rx_byte;
  } rx_item_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  in_action;
  logic [7:0]  in_rx_byte;
  logic        out_valid;
  logic        out_stall;
  logic [2:0]  out_result_code;
  logic [7:0]  out_resp_status;
  logic [10:0] out_frame_length;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  rx_item_t          pending_items[$];
  srfr_pkg::result_t expected_verdicts[$];
  srfr_pkg::result_t accepted_verdict;
  srfr_pkg::result_t wanted_verdict;
  int       items_queued = 0;
  int       error_count = 0;
  int       send_idle_pct = 0;
  int       recv_idle_pct = 0;
  int       hold_token = 0;
  int       hold_seen = 0;
  int       hold_left = 0;
  int       quiet_cycles = 0;

  // Copy of the receiver's registers and frame state
  logic [7:0]  cfg_opcode_q = srfr_pkg::OPCODE_RESET;
  logic [15:0] cfg_timeout_q = srfr_pkg::TIMEOUT_RESET;
  logic        rcv_armed = 1'b0;
  logic [1:0]  rcv_phase = srfr_pkg::PH_HUNT;
  logic        rcv_esc = 1'b0;
  int          rcv_count = 0;
  logic [7:0]  rcv_dir = '0;
  logic [7:0]  rcv_opcode = '0;
  logic [15:0] rcv_size = '0;
  logic [7:0]  rcv_status = '0;
  logic [15:0] rcv_ticks = '0;

  slip_response_frame_receiver #(
    .MAX_FRAME   (FRAME_CAP),
    .HEADER_BYTES(HDR_BYTES)
  ) u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_action       (in_action),
    .in_rx_byte      (in_rx_byte),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_result_code (out_result_code),
    .out_resp_status (out_resp_status),
    .out_frame_length(out_frame_length),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Advances the receiver copy by one item; returns 1 when a verdict results.
  function automatic bit predict_verdict(input logic [1:0] act, input logic [7:0] rx,
                                         output srfr_pkg::result_t verdict);
    logic [7:0] b;
    int         idx;
    b = rx;
    verdict = '0;
    if (act == srfr_pkg::ACT_ARM) begin
      rcv_armed = 1'b1;
      rcv_phase = srfr_pkg::PH_HUNT;
      rcv_esc = 1'b0;
      rcv_count = 0;
      rcv_dir = '0;
      rcv_opcode = '0;
      rcv_size = '0;
      rcv_status = '0;
      rcv_ticks = '0;
      return 1'b0;
    end
    if (!rcv_armed) return 1'b0;
    if (act == srfr_pkg::ACT_TICK) begin
      if (rcv_ticks != 16'hFFFF) rcv_ticks++;
      if (rcv_ticks >= cfg_timeout_q) begin
        verdict.result_code = srfr_pkg::RES_TIMEOUT;
        rcv_armed = 1'b0;
        return 1'b1;
      end
      return 1'b0;
    end
    if (act != srfr_pkg::ACT_BYTE) return 1'b0;

    if (rcv_phase == srfr_pkg::PH_HUNT) begin
      if (b == srfr_pkg::SLIP_END) rcv_phase = srfr_pkg::PH_SKIP;
      return 1'b0;
    end
    if (rcv_phase == srfr_pkg::PH_SKIP) begin
      if (b == srfr_pkg::SLIP_END) return 1'b0;
      rcv_phase = srfr_pkg::PH_BODY;
    end else if (b == srfr_pkg::SLIP_END) begin
      // Closing delimiter: the checks run in a fixed order of precedence.
      verdict.frame_length = 11'(rcv_count);
      if (rcv_count < HDR_BYTES + 4)
        verdict.result_code = srfr_pkg::RES_SHORT;
      else if (rcv_dir != srfr_pkg::DIR_RESPONSE)
        verdict.result_code = srfr_pkg::RES_NOT_RESP;
      else if (rcv_opcode != cfg_opcode_q)
        verdict.result_code = srfr_pkg::RES_OPCODE;
      else if (HDR_BYTES + int'(rcv_size) > rcv_count)
        verdict.result_code = srfr_pkg::RES_SIZE_BIG;
      else if (rcv_size < 4)
        verdict.result_code = srfr_pkg::RES_SIZE_LOW;
      else begin
        verdict.result_code = srfr_pkg::RES_OK;
        verdict.status = rcv_status;
      end
      rcv_armed = 1'b0;
      return 1'b1;
    end

    if (rcv_esc) begin
      rcv_esc = 1'b0;
      if (b == srfr_pkg::SLIP_ESC_END) b = srfr_pkg::SLIP_END;
      else if (b == srfr_pkg::SLIP_ESC_ESC) b = srfr_pkg::SLIP_ESC;
    end else if (b == srfr_pkg::SLIP_ESC) begin
      rcv_esc = 1'b1;
      return 1'b0;
    end

    idx = rcv_count;
    case (idx)
      0: rcv_dir = b;
      1: rcv_opcode = b;
      2: rcv_size[7:0] = b;
      3: rcv_size[15:8] = b;
      default: ;
    endcase
    if (idx >= 4 && rcv_size >= 4 && idx == HDR_BYTES + int'(rcv_size) - 4) rcv_status = b;
    rcv_count = idx + 1;
    if (rcv_count >= FRAME_CAP) begin
      verdict.result_code = srfr_pkg::RES_OVERFLOW;
      rcv_armed = 1'b0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // Sender: offers the oldest pending item and predicts it once transferred.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (in_valid) begin
        if (predict_verdict(in_action, in_rx_byte, accepted_verdict))
          expected_verdicts.push_back(accepted_verdict);
        void'(pending_items.pop_front());
      end
      if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid <= 1'b1;
        in_action <= pending_items[0].action;
        in_rx_byte <= pending_items[0].rx_byte;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: checks each verdict transfer and drives the output stall.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_left <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_verdicts.size() == 0) begin
          error_count++;
          if (error_count <= 10)
            $display("unexpected verdict: code %0d status %02h length %0d",
                     out_result_code, out_resp_status, out_frame_length);
        end else begin
          wanted_verdict = expected_verdicts.pop_front();
          if (out_result_code !== wanted_verdict.result_code ||
              out_resp_status !== wanted_verdict.status ||
              out_frame_length !== wanted_verdict.frame_length) begin
            error_count++;
            if (error_count <= 10)
              $display("verdict mismatch: expected code %0d status %02h length %0d, %s",
                       wanted_verdict.result_code, wanted_verdict.status,
                       wanted_verdict.frame_length,
                       $sformatf("got code %0d status %02h length %0d",
                                 out_result_code, out_resp_status, out_frame_length));
          end
        end
      end
      if (hold_seen != hold_token) begin
        hold_seen <= hold_token;
        hold_left <= HOLD_CYCLES;
        out_stall <= 1'b1;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (psel && penable && pready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic queue_item(input logic [1:0] act, input logic [7:0] b);
    rx_item_t item;
    item.action = act;
    item.rx_byte = b;
    pending_items.push_back(item);
    items_queued++;
  endtask

  // Returns once every item is transferred and every verdict has arrived, after an
  // extra wait that lets an item still inside the block without a verdict finish.
  task automatic wait_drained();
    while (pending_items.size() != 0 || in_valid || expected_verdicts.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Writes a register, then reads it back in a transfer that follows directly.
  task automatic cfg_write_check(input logic idx, input logic [31:0] value);
    logic [31:0] rdata;
    logic [31:0] want;
    want = (idx == srfr_pkg::REG_OPCODE) ? {24'd0, value[7:0]} : {16'd0, value[15:0]};
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(negedge clk); while (!pready);
    @(posedge clk);
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(negedge clk); while (!pready);
    rdata = prdata;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    if (idx == srfr_pkg::REG_OPCODE) cfg_opcode_q = value[7:0];
    else cfg_timeout_q = value[15:0];
    if (rdata !== want) begin
      error_count++;
      if (error_count <= 10)
        $display("register %0d read back %08h, expected %08h", idx, rdata, want);
    end
  endtask

  // One stretch of random traffic under one register setting. Most frames are
  // well formed with random content; the rest carry broken headers or sizes.
  task automatic run_phase(input logic [7:0] opc, input logic [15:0] ticks_allowed,
                           input int send_pct, input int recv_pct, input int budget,
                           input bit hold, input bit overflow);
    int         phase_end;
    int         kind;
    int         body_len;
    int         tick_pct;
    int         i;
    bit         garbled;
    logic [15:0] size_val;
    logic [7:0]  b;
    logic [7:0]  body[$];
    wait_drained();
    cfg_write_check(srfr_pkg::REG_OPCODE, {24'd0, opc});
    cfg_write_check(srfr_pkg::REG_TIMEOUT, {16'd0, ticks_allowed});
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    if (hold) hold_token++;
    phase_end = items_queued + budget;

    if (overflow) begin
      // A frame that never closes runs into the capacity limit.
      queue_item(srfr_pkg::ACT_ARM, 8'($urandom));
      queue_item(srfr_pkg::ACT_BYTE, srfr_pkg::SLIP_END);
      repeat (FRAME_CAP + 1) begin
        b = 8'($urandom);
        if (b == srfr_pkg::SLIP_END || b == srfr_pkg::SLIP_ESC) b = 8'h5A;
        queue_item(srfr_pkg::ACT_BYTE, b);
      end
      phase_end = items_queued + budget;
    end

    while (items_queued < phase_end) begin
      if ($urandom_range(9) == 0)
        repeat ($urandom_range(1, 3))
          queue_item(2'($urandom_range(1, 3)), 8'($urandom));
      queue_item(srfr_pkg::ACT_ARM, 8'($urandom));
      case ($urandom_range(5))
        0: tick_pct = 30;
        1, 2: tick_pct = 4;
        default: tick_pct = 0;
      endcase
      repeat ($urandom_range(0, 3)) begin
        b = 8'($urandom);
        if (b == srfr_pkg::SLIP_END) b = 8'h3C;
        queue_item(srfr_pkg::ACT_BYTE, b);
      end
      repeat ($urandom_range(1, 3)) queue_item(srfr_pkg::ACT_BYTE, srfr_pkg::SLIP_END);

      kind = $urandom_range(99);
      garbled = (kind >= 94);
      size_val = 16'($urandom_range(4, 24));
      body_len = HDR_BYTES + int'(size_val) +
                 (($urandom_range(3) == 0) ? $urandom_range(1, 4) : 0);
      if (kind >= 70 && kind < 78) begin
        size_val = 16'($urandom_range(0, 3));
        body_len = HDR_BYTES + 4 + $urandom_range(0, 4);
      end else if (kind >= 78 && kind < 86) begin
        size_val = $urandom_range(1) ? 16'($urandom) : 16'($urandom_range(25, 40));
        body_len = HDR_BYTES + $urandom_range(4, 24);
      end else if (kind >= 86 && kind < 94) begin
        body_len = $urandom_range(1, HDR_BYTES + 3);
      end

      body.delete();
      for (i = 0; i < body_len; i++) begin
        b = 8'($urandom);
        if (!garbled) begin
          if (i == 0 && $urandom_range(9) != 0) b = srfr_pkg::DIR_RESPONSE;
          else if (i == 1 && $urandom_range(7) != 0) b = opc;
          else if (i == 2) b = size_val[7:0];
          else if (i == 3) b = size_val[15:8];
          else if (i >= 4 && $urandom_range(4) == 0)
            case ($urandom_range(3))
              0: b = srfr_pkg::SLIP_END;
              1: b = srfr_pkg::SLIP_ESC;
              2: b = srfr_pkg::SLIP_ESC_END;
              default: b = srfr_pkg::SLIP_ESC_ESC;
            endcase
        end
        body.push_back(b);
      end

      foreach (body[j]) begin
        if ($urandom_range(99) < tick_pct) queue_item(srfr_pkg::ACT_TICK, 8'($urandom));
        if (body[j] == srfr_pkg::SLIP_END) begin
          queue_item(srfr_pkg::ACT_BYTE, srfr_pkg::SLIP_ESC);
          queue_item(srfr_pkg::ACT_BYTE, srfr_pkg::SLIP_ESC_END);
        end else if (body[j] == srfr_pkg::SLIP_ESC) begin
          queue_item(srfr_pkg::ACT_BYTE, srfr_pkg::SLIP_ESC);
          queue_item(srfr_pkg::ACT_BYTE, srfr_pkg::SLIP_ESC_ESC);
        end else begin
          // An escape before an ordinary byte lets the byte through as it is.
          if ($urandom_range(19) == 0) queue_item(srfr_pkg::ACT_BYTE, srfr_pkg::SLIP_ESC);
          queue_item(srfr_pkg::ACT_BYTE, body[j]);
        end
      end
      if ($urandom_range(29) == 0) queue_item(srfr_pkg::ACT_BYTE, srfr_pkg::SLIP_ESC);
      // Now and then a frame is left open and the next arm restarts the wait.
      if ($urandom_range(19) != 0) queue_item(srfr_pkg::ACT_BYTE, srfr_pkg::SLIP_END);
    end
  endtask

  rx_item_t opening_items[$];

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_action = srfr_pkg::ACT_ARM;
    in_rx_byte = 8'h00;
    out_stall = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    send_idle_pct = 27;
    recv_idle_pct = 81;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    cfg_write_check(srfr_pkg::REG_OPCODE, {24'd0, srfr_pkg::OPCODE_RESET});
    cfg_write_check(srfr_pkg::REG_TIMEOUT, 32'd3);
    opening_items = '{
      // nothing happens while the receiver is not armed
      '{srfr_pkg::ACT_BYTE, 8'hFF}, '{ACT_NONE, 8'h00},
      // noise before the first delimiter, a repeated delimiter, then a good
      // response whose status byte arrives escaped
      '{srfr_pkg::ACT_ARM, 8'hFF}, '{srfr_pkg::ACT_BYTE, 8'h00},
      '{srfr_pkg::ACT_BYTE, srfr_pkg::SLIP_END}, '{srfr_pkg::ACT_BYTE, srfr_pkg::SLIP_END},
      '{srfr_pkg::ACT_BYTE, srfr_pkg::DIR_RESPONSE}, '{srfr_pkg::ACT_BYTE, 8'h08},
      '{srfr_pkg::ACT_BYTE, 8'h04}, '{srfr_pkg::ACT_BYTE, 8'h00},
      '{srfr_pkg::ACT_BYTE, srfr_pkg::SLIP_ESC}, '{srfr_pkg::ACT_BYTE, srfr_pkg::SLIP_ESC_ESC},
      '{srfr_pkg::ACT_BYTE, srfr_pkg::SLIP_ESC}, '{srfr_pkg::ACT_BYTE, 8'h7E},
      '{srfr_pkg::ACT_BYTE, 8'h00}, '{srfr_pkg::ACT_BYTE, 8'hFF},
      '{srfr_pkg::ACT_BYTE, srfr_pkg::SLIP_ESC}, '{srfr_pkg::ACT_BYTE, srfr_pkg::SLIP_ESC_END},
      '{srfr_pkg::ACT_BYTE, 8'h11}, '{srfr_pkg::ACT_BYTE, 8'h22},
      '{srfr_pkg::ACT_BYTE, 8'h33}, '{srfr_pkg::ACT_BYTE, srfr_pkg::SLIP_END},
      // a delimiter straight after an escape still closes the frame
      '{srfr_pkg::ACT_ARM, 8'h00}, '{srfr_pkg::ACT_BYTE, srfr_pkg::SLIP_END},
      '{srfr_pkg::ACT_BYTE, srfr_pkg::DIR_RESPONSE},
      '{srfr_pkg::ACT_BYTE, srfr_pkg::SLIP_ESC}, '{srfr_pkg::ACT_BYTE, srfr_pkg::SLIP_END},
      // the third tick runs out the wait
      '{srfr_pkg::ACT_ARM, 8'h00}, '{srfr_pkg::ACT_TICK, 8'h00},
      '{srfr_pkg::ACT_TICK, 8'hFF}, '{srfr_pkg::ACT_TICK, 8'h00}
    };
    foreach (opening_items[i]) queue_item(opening_items[i].action, opening_items[i].rx_byte);

    run_phase(8'hFF, 16'hFFFF, 27, 81, 300, 1'b0, 1'b0);
    run_phase(8'h00, 16'h0000, 81, 27, 300, 1'b0, 1'b0);
    run_phase(8'($urandom), 16'h0001, 0, 0, 250, 1'b1, 1'b0);
    run_phase(8'($urandom), 16'($urandom_range(8, 40)), 0, 0, 50, 1'b0, 1'b1);
    wait_drained();
    repeat (10) @(posedge clk);

    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/srfr_pkg.sv
rtl/srfr_cfg_regs.sv
rtl/srfr_core.sv
rtl/srfr_out_buf.sv
rtl/slip_response_frame_receiver.sv
test/slip_response_frame_receiver_tb.sv
